// ----- rtl/rgsb_pkg.sv -----
package rgsb_pkg;

	// Command codes carried in the low bits of the input tuser.
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_SEED  = 2'd1,
		CMD_FETCH = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Register select, taken from paddr[2].
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam int          GEOM_W     = 7;
	localparam logic [6:0]  GEOM_RESET = 7'd64;

	// Fill direction of a stack entry: up, right, down, left, then spent.
	localparam logic [2:0] DIR_UP    = 3'd0;
	localparam logic [2:0] DIR_RIGHT = 3'd1;
	localparam logic [2:0] DIR_DOWN  = 3'd2;
	localparam logic [2:0] DIR_LEFT  = 3'd3;
	localparam logic [2:0] DIR_DONE  = 3'd4;

	// Neighbor order of the border test.
	localparam logic [1:0] NB_UP    = 2'd0;
	localparam logic [1:0] NB_DOWN  = 2'd1;
	localparam logic [1:0] NB_LEFT  = 2'd2;
	localparam logic [1:0] NB_RIGHT = 2'd3;

	typedef struct packed {
		logic [2:0]        dir;
		logic [GEOM_W-1:0] row;
		logic [GEOM_W-1:0] col;
	} stk_ent_t;

	localparam int STK_W = 3 + 2 * GEOM_W;

endpackage

// ----- rtl/rgsb_ram.sv -----
module rgsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/rgsb_div.sv -----
module rgsb_div #(
	parameter int IW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [IW-1:0] dividend,
	input  logic [6:0]    divisor,
	output logic          done,
	output logic [IW-1:0] quotient,
	output logic [6:0]    remainder
);

	localparam int CNTW = (IW > 1) ? $clog2(IW) : 1;

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [IW-1:0]   dvd_q;
	logic [IW-1:0]   quo_q;
	logic [6:0]      rem_q;
	logic [7:0]      trial;
	logic            qbit;
	logic [7:0]      rem_next;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	assign trial    = {rem_q, dvd_q[IW-1]};
	assign qbit     = (trial >= {1'b0, divisor});
	assign rem_next = qbit ? (trial - {1'b0, divisor}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(IW - 1);
				dvd_q  <= dividend;
				quo_q  <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= dvd_q << 1;
				quo_q <= IW'({quo_q, qbit});
				rem_q <= rem_next[6:0];
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/region_grow_segment_border.sv -----
// Seeded region grower with a border scan for gray images.
// The input stream carries one command per word. A load word writes the next
// pixel in row-major order; with the first-pixel flag set it also starts a new
// frame, which clears every label with a sweep over all MAX_ROWS*MAX_COLS entries.
// A seed word grows a 4-connected region from the seed point by a depth-first
// fill over a stack memory. A pixel joins while its distance from the running
// mean stays within the criterion. A fetch word returns one output word: the
// next border pixel in raster order, or found = 0 once the scan is exhausted.
// Only fetch words produce output words.
// Steps: after the column register was written, a load or fetch first recounts
// its pointer's row and column with the serial divider. A seed checks the seed
// label, then walks the stack top through up, right, down and left; a direction
// on the image reads the label and pixel there, and a free pixel is tested
// against the mean with the one shared multiplier (the first pixel joins
// untested) and joins or is rejected. A spent stack entry is popped. A fetch
// reads the label of each scanned pixel and of its neighbors on the image.
// The block takes no word while a command is at work. After reset the label
// memory is swept to zero over all its entries before the first word is taken;
// register writes are taken at any time. When the receiver stalls, the result
// waits in the output register and a following fetch waits for it.
module region_grow_segment_border #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int PIXEL_BITS = 8,
	parameter int LABEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // pixel_value[7:0], seed_row[13:8], seed_col[19:14],
	                              // criterion[27:20], zero pad[31:28]
	input  logic [2:0]  s_tuser,  // command[1:0], first_pixel[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // border_row[5:0], border_col[11:6], zero pad[15:12]
	output logic [0:0]  m_tuser   // found[0]
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = $clog2(DEPTH + 1);
	localparam int CW    = IW;
	localparam int MW    = (PIXEL_BITS > 8) ? PIXEL_BITS : 8;
	localparam int PW    = MW + CW;
	localparam int SW    = PIXEL_BITS + CW;
	localparam int XW    = (IW > 14) ? IW : 14;
	localparam int TW    = ((AW > 17) ? AW : 17) + 1;
	localparam int ROWS_CAP_I = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
	localparam int COLS_CAP_I = (MAX_COLS > 127) ? 127 : MAX_COLS;
	localparam logic [6:0] ROWS_CAP = 7'(ROWS_CAP_I);
	localparam logic [6:0] COLS_CAP = 7'(COLS_CAP_I);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LOAD, S_DIV, S_SEED_RD, S_SEED_CHK,
		S_J_RD, S_J_LBL, S_J_MUL1, S_J_MUL2, S_J_CMP, S_J_ADD,
		S_LOOP, S_POP, S_FCHK, S_FCTR, S_FNB, S_FNBD, S_FOUT
	} state_t;

	state_t state_q;

	// Configuration registers and clamped geometry.
	logic [6:0]  rows_q, cols_q, rows_eff, cols_eff;
	logic [13:0] total;
	logic [XW-1:0] total_x, load_x, scan_x;
	logic        cfg_wr;

	// Frame pointers.
	logic [IW-1:0] load_idx_q, scan_idx_q;
	logic [6:0]    load_r_q, load_c_q, scan_r_q, scan_c_q;
	logic          load_dirty_q, scan_dirty_q;

	// Latched command fields.
	logic [PIXEL_BITS-1:0] pix_q;
	logic [6:0]            seed_r_q, seed_c_q;
	logic [7:0]            crit_q;

	// Region growing state.
	logic [LABEL_BITS-1:0] cur_label_q;
	logic [SW-1:0]         sum_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         sp_q, sp_m1, sp_m2;
	rgsb_pkg::stk_ent_t    top_q;
	logic [6:0]            join_r_q, join_c_q;
	logic [PIXEL_BITS-1:0] pix_v_q;
	logic [PW-1:0]         prod_q, diff_q, sum_x, mul_p;
	logic [MW-1:0]         mul_a;

	// Clear sweep.
	logic [AW-1:0] clr_cnt_q;
	logic          clr_load_q;

	// Divider.
	logic          div_start, div_done, div_load_q;
	logic [IW-1:0] div_dvd, div_quo;
	logic [6:0]    div_rem;

	// Border scan.
	logic [6:0]            fr_q, fc_q;
	logic [LABEL_BITS-1:0] center_q;
	logic [1:0]            nb_q;

	// Output register.
	logic       m_valid_q, found_q, out_found_q;
	logic [5:0] out_r_q, out_c_q;

	// Neighbor selection.
	logic       loop_ok, fet_ok;
	logic [6:0] loop_r, loop_c, fet_r, fet_c;

	// Memory ports.
	logic                  img_we, lbl_we, stk_we;
	logic [AW-1:0]         img_waddr, img_raddr, lbl_waddr, lbl_raddr, stk_waddr, stk_raddr;
	logic [PIXEL_BITS-1:0] img_wdata, img_rdata;
	logic [LABEL_BITS-1:0] lbl_wdata, lbl_rdata;
	logic [rgsb_pkg::STK_W-1:0] stk_rdata;

	rgsb_pkg::cmd_t in_cmd;

	function automatic logic [AW-1:0] pix_addr(input logic [6:0] r, input logic [6:0] c);
		logic [TW-1:0] t;
		t = TW'(r) * TW'(MAX_COLS) + TW'(c);
		return t[AW-1:0];
	endfunction

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {25'd0, (paddr[2] == rgsb_pkg::REG_COLS) ? cols_q : rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= rgsb_pkg::GEOM_RESET;
			cols_q <= rgsb_pkg::GEOM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == rgsb_pkg::REG_ROWS) begin
				rows_q <= pwdata[6:0];
			end else begin
				cols_q <= pwdata[6:0];
			end
		end
	end

	assign rows_eff = (rows_q > ROWS_CAP) ? ROWS_CAP : rows_q;
	assign cols_eff = (cols_q > COLS_CAP) ? COLS_CAP : cols_q;
	assign total    = 14'(rows_eff) * 14'(cols_eff);
	assign total_x  = XW'(total);
	assign load_x   = XW'(load_idx_q);
	assign scan_x   = XW'(scan_idx_q);
	assign sp_m1    = sp_q - IW'(1);
	assign sp_m2    = sp_q - IW'(2);
	assign in_cmd   = rgsb_pkg::cmd_t'(s_tuser[1:0]);

	// Neighbor of the stack top for the fill walk.
	always_comb begin
		loop_r  = top_q.row;
		loop_c  = top_q.col;
		loop_ok = 1'b0;
		unique case (top_q.dir)
			rgsb_pkg::DIR_UP: begin
				loop_ok = (top_q.row != 7'd0);
				loop_r  = top_q.row - 7'd1;
			end
			rgsb_pkg::DIR_RIGHT: begin
				loop_ok = ({1'b0, top_q.col} + 8'd1) < {1'b0, cols_eff};
				loop_c  = top_q.col + 7'd1;
			end
			rgsb_pkg::DIR_DOWN: begin
				loop_ok = ({1'b0, top_q.row} + 8'd1) < {1'b0, rows_eff};
				loop_r  = top_q.row + 7'd1;
			end
			rgsb_pkg::DIR_LEFT: begin
				loop_ok = (top_q.col != 7'd0);
				loop_c  = top_q.col - 7'd1;
			end
			default: loop_ok = 1'b0;
		endcase
	end

	// Neighbor of the scanned pixel for the border test.
	always_comb begin
		fet_r  = fr_q;
		fet_c  = fc_q;
		fet_ok = 1'b0;
		unique case (nb_q)
			rgsb_pkg::NB_UP: begin
				fet_ok = (fr_q != 7'd0);
				fet_r  = fr_q - 7'd1;
			end
			rgsb_pkg::NB_DOWN: begin
				fet_ok = ({1'b0, fr_q} + 8'd1) < {1'b0, rows_eff};
				fet_r  = fr_q + 7'd1;
			end
			rgsb_pkg::NB_LEFT: begin
				fet_ok = (fc_q != 7'd0);
				fet_c  = fc_q - 7'd1;
			end
			rgsb_pkg::NB_RIGHT: begin
				fet_ok = ({1'b0, fc_q} + 8'd1) < {1'b0, cols_eff};
				fet_c  = fc_q + 7'd1;
			end
			default: fet_ok = 1'b0;
		endcase
	end

	// Memory port steering.
	always_comb begin
		unique case (state_q)
			S_SEED_RD: lbl_raddr = pix_addr(seed_r_q, seed_c_q);
			S_FCHK:    lbl_raddr = pix_addr(scan_r_q, scan_c_q);
			S_FNB:     lbl_raddr = pix_addr(fet_r, fet_c);
			default:   lbl_raddr = pix_addr(join_r_q, join_c_q);
		endcase
	end

	assign lbl_we    = (state_q == S_CLEAR) || (state_q == S_J_ADD);
	assign lbl_waddr = (state_q == S_CLEAR) ? clr_cnt_q : pix_addr(join_r_q, join_c_q);
	assign lbl_wdata = (state_q == S_CLEAR) ? '0 : cur_label_q;

	assign img_we    = (state_q == S_LOAD) && (load_x < total_x) && !load_dirty_q;
	assign img_waddr = pix_addr(load_r_q, load_c_q);
	assign img_wdata = pix_q;
	assign img_raddr = pix_addr(join_r_q, join_c_q);

	assign stk_we    = (state_q == S_J_ADD) && (XW'(sp_q) < XW'(DEPTH)) && (sp_q != '0);
	assign stk_waddr = sp_m1[AW-1:0];
	assign stk_raddr = sp_m2[AW-1:0];

	// Shared multiplier of the mean test: value*count, then criterion*count.
	assign mul_a = (state_q == S_J_MUL1) ? MW'(pix_v_q) : MW'(crit_q);
	assign mul_p = PW'(mul_a) * PW'(count_q);
	assign sum_x = PW'(sum_q);

	assign div_start = ((state_q == S_LOAD) && (load_x < total_x) && load_dirty_q) ||
	                   ((state_q == S_FCHK) && (scan_x < total_x) && scan_dirty_q);
	assign div_dvd   = (state_q == S_LOAD) ? load_idx_q : scan_idx_q;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_cnt_q    <= '0;
			clr_load_q   <= 1'b0;
			load_idx_q   <= '0;
			load_r_q     <= '0;
			load_c_q     <= '0;
			scan_idx_q   <= '0;
			scan_r_q     <= '0;
			scan_c_q     <= '0;
			load_dirty_q <= 1'b0;
			scan_dirty_q <= 1'b0;
			cur_label_q  <= '0;
			sum_q        <= '0;
			count_q      <= '0;
			sp_q         <= '0;
			top_q        <= '0;
			join_r_q     <= '0;
			join_c_q     <= '0;
			pix_v_q      <= '0;
			prod_q       <= '0;
			diff_q       <= '0;
			pix_q        <= '0;
			seed_r_q     <= '0;
			seed_c_q     <= '0;
			crit_q       <= '0;
			div_load_q   <= 1'b0;
			fr_q         <= '0;
			fc_q         <= '0;
			center_q     <= '0;
			nb_q         <= '0;
			m_valid_q    <= 1'b0;
			found_q      <= 1'b0;
			out_found_q  <= 1'b0;
			out_r_q      <= '0;
			out_c_q      <= '0;
		end else begin
			// The output register empties on a taken word unless a new result
			// refills it in the same cycle.
			if (m_valid_q && m_tready && (state_q != S_FOUT)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (AW'(DEPTH - 1) == clr_cnt_q) begin
						state_q <= clr_load_q ? S_LOAD : S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						pix_q    <= PIXEL_BITS'(s_tdata[7:0]);
						seed_r_q <= {1'b0, s_tdata[13:8]};
						seed_c_q <= {1'b0, s_tdata[19:14]};
						crit_q   <= s_tdata[27:20];
						unique case (in_cmd)
							rgsb_pkg::CMD_LOAD: begin
								if (s_tuser[2]) begin
									load_idx_q   <= '0;
									load_r_q     <= '0;
									load_c_q     <= '0;
									scan_idx_q   <= '0;
									scan_r_q     <= '0;
									scan_c_q     <= '0;
									load_dirty_q <= 1'b0;
									scan_dirty_q <= 1'b0;
									cur_label_q  <= '0;
									clr_cnt_q    <= '0;
									clr_load_q   <= 1'b1;
									state_q      <= S_CLEAR;
								end else begin
									state_q <= S_LOAD;
								end
							end
							rgsb_pkg::CMD_SEED:  state_q <= S_SEED_RD;
							rgsb_pkg::CMD_FETCH: state_q <= S_FCHK;
							default:             state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: begin
					if (load_x < total_x) begin
						if (load_dirty_q) begin
							div_load_q <= 1'b1;
							state_q    <= S_DIV;
						end else begin
							load_idx_q <= load_idx_q + 1'b1;
							if (({1'b0, load_c_q} + 8'd1) == {1'b0, cols_eff}) begin
								load_c_q <= '0;
								load_r_q <= load_r_q + 7'd1;
							end else begin
								load_c_q <= load_c_q + 7'd1;
							end
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_load_q) begin
							load_r_q     <= 7'(div_quo);
							load_c_q     <= div_rem;
							load_dirty_q <= 1'b0;
							state_q      <= S_LOAD;
						end else begin
							scan_r_q     <= 7'(div_quo);
							scan_c_q     <= div_rem;
							scan_dirty_q <= 1'b0;
							state_q      <= S_FCHK;
						end
					end
				end
				S_SEED_RD: begin
					if ((seed_r_q < rows_eff) && (seed_c_q < cols_eff)) begin
						state_q <= S_SEED_CHK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SEED_CHK: begin
					if (lbl_rdata != '0) begin
						state_q <= S_IDLE;
					end else begin
						if (cur_label_q != '1) begin
							cur_label_q <= cur_label_q + 1'b1;
						end
						sum_q    <= '0;
						count_q  <= '0;
						sp_q     <= '0;
						join_r_q <= seed_r_q;
						join_c_q <= seed_c_q;
						state_q  <= S_J_RD;
					end
				end
				S_J_RD: state_q <= S_J_LBL;
				S_J_LBL: begin
					pix_v_q <= img_rdata;
					if (lbl_rdata != '0) begin
						state_q <= S_LOOP;
					end else if (count_q == '0) begin
						state_q <= S_J_ADD;
					end else begin
						state_q <= S_J_MUL1;
					end
				end
				S_J_MUL1: begin
					prod_q  <= mul_p;
					state_q <= S_J_MUL2;
				end
				S_J_MUL2: begin
					diff_q  <= (sum_x >= prod_q) ? (sum_x - prod_q) : (prod_q - sum_x);
					prod_q  <= mul_p;
					state_q <= S_J_CMP;
				end
				S_J_CMP: state_q <= (diff_q <= prod_q) ? S_J_ADD : S_LOOP;
				S_J_ADD: begin
					sum_q   <= sum_q + SW'(pix_v_q);
					count_q <= count_q + 1'b1;
					if (XW'(sp_q) < XW'(DEPTH)) begin
						top_q.dir <= rgsb_pkg::DIR_UP;
						top_q.row <= join_r_q;
						top_q.col <= join_c_q;
						sp_q      <= sp_q + 1'b1;
					end
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (sp_q == '0) begin
						state_q <= S_IDLE;
					end else if (top_q.dir >= rgsb_pkg::DIR_DONE) begin
						sp_q <= sp_m1;
						if (sp_q >= IW'(2)) begin
							state_q <= S_POP;
						end
					end else begin
						top_q.dir <= top_q.dir + 3'd1;
						if (loop_ok) begin
							join_r_q <= loop_r;
							join_c_q <= loop_c;
							state_q  <= S_J_RD;
						end
					end
				end
				S_POP: begin
					top_q   <= rgsb_pkg::stk_ent_t'(stk_rdata);
					state_q <= S_LOOP;
				end
				S_FCHK: begin
					if (scan_x < total_x) begin
						if (scan_dirty_q) begin
							div_load_q <= 1'b0;
							state_q    <= S_DIV;
						end else begin
							fr_q       <= scan_r_q;
							fc_q       <= scan_c_q;
							scan_idx_q <= scan_idx_q + 1'b1;
							if (({1'b0, scan_c_q} + 8'd1) == {1'b0, cols_eff}) begin
								scan_c_q <= '0;
								scan_r_q <= scan_r_q + 7'd1;
							end else begin
								scan_c_q <= scan_c_q + 7'd1;
							end
							state_q <= S_FCTR;
						end
					end else begin
						found_q <= 1'b0;
						fr_q    <= '0;
						fc_q    <= '0;
						state_q <= S_FOUT;
					end
				end
				S_FCTR: begin
					center_q <= lbl_rdata;
					nb_q     <= rgsb_pkg::NB_UP;
					state_q  <= S_FNB;
				end
				S_FNB: begin
					if (fet_ok) begin
						state_q <= S_FNBD;
					end else if (nb_q == rgsb_pkg::NB_RIGHT) begin
						state_q <= S_FCHK;
					end else begin
						nb_q <= nb_q + 2'd1;
					end
				end
				S_FNBD: begin
					if (lbl_rdata != center_q) begin
						found_q <= 1'b1;
						state_q <= S_FOUT;
					end else if (nb_q == rgsb_pkg::NB_RIGHT) begin
						state_q <= S_FCHK;
					end else begin
						nb_q    <= nb_q + 2'd1;
						state_q <= S_FNB;
					end
				end
				S_FOUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q   <= 1'b1;
						out_found_q <= found_q;
						out_r_q     <= found_q ? fr_q[5:0] : 6'd0;
						out_c_q     <= found_q ? fc_q[5:0] : 6'd0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// A new column count moves the row/column split of both pointers.
			if (cfg_wr && (paddr[2] == rgsb_pkg::REG_COLS)) begin
				load_dirty_q <= 1'b1;
				scan_dirty_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, out_c_q, out_r_q};
	assign m_tuser  = out_found_q;

	rgsb_div #(.IW(IW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (cols_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	rgsb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_img_ram (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (img_wdata),
		.raddr (img_raddr),
		.rdata (img_rdata)
	);

	rgsb_ram #(.WIDTH(LABEL_BITS), .DEPTH(DEPTH)) u_lbl_ram (
		.clk   (clk),
		.we    (lbl_we),
		.waddr (lbl_waddr),
		.wdata (lbl_wdata),
		.raddr (lbl_raddr),
		.rdata (lbl_rdata)
	);

	rgsb_ram #(.WIDTH(rgsb_pkg::STK_W), .DEPTH(DEPTH)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (top_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// The fill stack is empty whenever the block waits for a word.
	a_stack_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (sp_q == '0))
		else $error("fill stack not empty in idle");

	// A region never holds more pixels than the image store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(DEPTH))
		else $error("region count beyond store depth");

	// An exhausted scan reports a zero position.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !out_found_q) |-> (m_tdata == 16'd0))
		else $error("position given with found low");

	// A pixel joins only after its label was read as free.
	a_join_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_J_ADD) |-> (($past(state_q) == S_J_LBL) || ($past(state_q) == S_J_CMP)))
		else $error("join without label check");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the region grower with border scan.
// A shadow model of the block runs beside it: loads, seeds and fetches are
// predicted as each input word is presented, and every output word is checked
// against the oldest predicted border result.
module tb_top;

	localparam int NR = 64;
	localparam int NC = 64;
	localparam int NPIX = NR * NC;

	// One input word as the driver sends it.
	typedef struct {
		rgsb_pkg::cmd_t cmd;
		logic [7:0]     pix;
		logic           first;
		logic [5:0]     srow;
		logic [5:0]     scol;
		logic [7:0]     crit;
	} word_t;

	// One predicted output word.
	typedef struct {
		logic       found;
		logic [5:0] row;
		logic [5:0] col;
	} border_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;

	region_grow_segment_border u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Shadow state of the block.
	int unsigned   sh_rows, sh_cols;
	logic [7:0]    sh_pix [NPIX];
	int unsigned   sh_lab [NPIX];
	int unsigned   stk_addr [NPIX];
	int unsigned   stk_dir [NPIX];
	int unsigned   stk_ptr;
	longint unsigned reg_sum, reg_cnt;
	int unsigned   cur_label, load_idx, scan_idx;

	word_t   pending_words[$];
	border_t border_q[$];
	int      err_count;
	int      words_sent, words_taken, fetch_count, found_count, seed_count;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	function automatic int unsigned pix_addr(int unsigned r, int unsigned c);
		return (r * NC + c) % NPIX;
	endfunction

	// Test one neighbor against the running mean; join and push it if close.
	function automatic void join_test(int unsigned r, int unsigned c, longint unsigned crit);
		int unsigned a;
		longint unsigned v, lhs, rhs, lim;
		a = pix_addr(r, c);
		v = sh_pix[a];
		if (sh_lab[a] != 0) return;
		if (reg_cnt == 0) begin
			lhs = v; rhs = v; lim = 0;
		end else begin
			lhs = reg_sum; rhs = v * reg_cnt; lim = crit * reg_cnt;
		end
		if ((lhs > rhs) ? (lhs - rhs) > lim : (rhs - lhs) > lim) return;
		sh_lab[a] = cur_label;
		reg_sum += v;
		reg_cnt += 1;
		if (stk_ptr < NPIX) begin
			stk_addr[stk_ptr] = a;
			stk_dir[stk_ptr] = 0;
			stk_ptr++;
		end
	endfunction

	// Depth-first fill in the order up, right, down, left.
	function automatic void grow_region(int unsigned r0, int unsigned c0, longint unsigned crit);
		int unsigned top, a, r, c, d;
		reg_sum = 0;
		reg_cnt = 0;
		stk_ptr = 0;
		join_test(r0, c0, crit);
		while (stk_ptr > 0) begin
			top = stk_ptr - 1;
			a = stk_addr[top];
			r = a / NC;
			c = a % NC;
			d = stk_dir[top];
			if (d >= 4) begin
				stk_ptr--;
			end else begin
				stk_dir[top] = d + 1;
				if (d == 0 && r > 0) join_test(r - 1, c, crit);
				else if (d == 1 && c + 1 < sh_cols) join_test(r, c + 1, crit);
				else if (d == 2 && r + 1 < sh_rows) join_test(r + 1, c, crit);
				else if (d == 3 && c > 0) join_test(r, c - 1, crit);
			end
		end
	endfunction

	function automatic bit on_border(int unsigned r, int unsigned c);
		int unsigned l;
		l = sh_lab[pix_addr(r, c)];
		if (r > 0 && sh_lab[pix_addr(r - 1, c)] != l) return 1;
		if (r + 1 < sh_rows && sh_lab[pix_addr(r + 1, c)] != l) return 1;
		if (c > 0 && sh_lab[pix_addr(r, c - 1)] != l) return 1;
		if (c + 1 < sh_cols && sh_lab[pix_addr(r, c + 1)] != l) return 1;
		return 0;
	endfunction

	// Advance the shadow model by one input word as the driver presents it.
	function automatic void predict_word(word_t w);
		int unsigned total, r, c;
		border_t b;
		total = sh_rows * sh_cols;
		case (w.cmd)
			rgsb_pkg::CMD_LOAD: begin
				if (w.first) begin
					load_idx = 0;
					scan_idx = 0;
					cur_label = 0;
					foreach (sh_lab[i]) sh_lab[i] = 0;
				end
				if (load_idx < total) begin
					sh_pix[pix_addr(load_idx / sh_cols, load_idx % sh_cols)] = w.pix;
					load_idx++;
				end
			end
			rgsb_pkg::CMD_SEED: begin
				if (w.srow < sh_rows && w.scol < sh_cols &&
				    sh_lab[pix_addr(w.srow, w.scol)] == 0) begin
					if (cur_label < 65535) cur_label++;
					seed_count++;
					grow_region(w.srow, w.scol, w.crit);
				end
			end
			rgsb_pkg::CMD_FETCH: begin
				b = '{found: 1'b0, row: 6'd0, col: 6'd0};
				while (scan_idx < total) begin
					r = scan_idx / sh_cols;
					c = scan_idx % sh_cols;
					scan_idx++;
					if (on_border(r, c)) begin
						b = '{found: 1'b1, row: r[5:0], col: c[5:0]};
						break;
					end
				end
				border_q.push_back(b);
			end
			default: ;
		endcase
	endfunction

	// Idle bursts: the source and sink pause now and then, none once calm is set.
	bit calm;
	int src_gap, snk_gap;

	// The rising-edge sampling of the input handshake; the driver then reacts at
	// the next falling edge, so no result depends on event order within a step.
	logic in_fire;
	always @(posedge clk) begin
		in_fire <= arst_n && s_tvalid && s_tready;
	end

	// Driver: presents the oldest pending word, updates at the falling edge.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			src_gap  = 0;
		end else begin
			logic busy;
			busy = s_tvalid && !in_fire;
			if (!busy) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					src_gap = $urandom_range(1, 6) - 1;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					word_t w;
					w = pending_words.pop_front();
					predict_word(w);
					words_sent++;
					s_tvalid <= 1'b1;
					s_tdata  <= {4'd0, w.crit, w.scol, w.srow, w.pix};
					s_tuser  <= {w.first, w.cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) if (arst_n && s_tvalid && s_tready) words_taken++;

	// Sink stall bursts, changed at the falling edge.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap  = 0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			snk_gap = $urandom_range(1, 6) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: each accepted output word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (border_q.size() == 0) begin
				report_mismatch("unexpected output word", m_tdata, 0);
			end else begin
				border_t e;
				e = border_q.pop_front();
				fetch_count++;
				if (e.found) found_count++;
				if (m_tuser[0] !== e.found) report_mismatch("found", m_tuser[0], e.found);
				if (m_tdata[5:0] !== e.row) report_mismatch("border_row", m_tdata[5:0], e.row);
				if (m_tdata[11:6] !== e.col) report_mismatch("border_col", m_tdata[11:6], e.col);
				if (m_tdata[15:12] !== 4'd0) report_mismatch("pad", m_tdata[15:12], 0);
			end
		end
	end

	// Register write in setup and access phases; pready is always high.
	task automatic write_geometry(input logic sel, input int unsigned val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {sel, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (sel == rgsb_pkg::REG_ROWS) sh_rows = (val & 7'h7f) > NR ? NR : (val & 7'h7f);
		else sh_cols = (val & 7'h7f) > NC ? NC : (val & 7'h7f);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Wait for all queued words to be taken, every fetch answered and the block
	// back at rest, so that geometry changes only while nothing is in flight.
	task automatic drain();
		while (pending_words.size() > 0 || s_tvalid || border_q.size() > 0 || !s_tready)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic word_t mk(rgsb_pkg::cmd_t c, logic [7:0] p, logic f, logic [5:0] r,
	                              logic [5:0] col, logic [7:0] cr);
		word_t w;
		w.cmd = c; w.pix = p; w.first = f; w.srow = r; w.scol = col; w.crit = cr;
		return w;
	endfunction

	// Load a whole frame; style picks flat patches, a ramp or noise.
	task automatic queue_frame(int unsigned rows, int unsigned cols, int style);
		for (int i = 0; i < rows * cols; i++) begin
			logic [7:0] p;
			case (style)
				0: p = ((i / cols) / 2 + (i % cols) / 3) % 2 ? 8'hff : 8'h00;
				1: p = 8'((i * 37) & 8'hff);
				default: p = 8'($urandom_range(0, 255));
			endcase
			pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, p, i == 0, 6'($urandom),
				6'($urandom), 8'($urandom)));
		end
	endtask

	// Seeds and fetches with random content, a few noise words, then a run of fetches.
	task automatic queue_work(int unsigned rows, int unsigned cols, int nseeds);
		for (int i = 0; i < nseeds; i++) begin
			int k;
			k = $urandom_range(0, 9);
			if (k < 6)
				pending_words.push_back(mk(rgsb_pkg::CMD_SEED, 8'($urandom), 1'($urandom),
					6'($urandom_range(0, rows - 1)), 6'($urandom_range(0, cols - 1)),
					8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40))));
			else if (k < 8)
				pending_words.push_back(mk(rgsb_pkg::CMD_FETCH, 8'($urandom), 1'($urandom),
					6'($urandom), 6'($urandom), 8'($urandom)));
			else if (k == 8)
				pending_words.push_back(mk(rgsb_pkg::CMD_NONE, 8'($urandom), 1'($urandom),
					6'($urandom), 6'($urandom), 8'($urandom)));
			else
				pending_words.push_back(mk(rgsb_pkg::CMD_SEED, 8'($urandom), 1'($urandom),
					6'($urandom), 6'($urandom), 8'($urandom)));
		end
		for (int i = 0; i < rows * cols / 4 + 3; i++)
			pending_words.push_back(mk(rgsb_pkg::CMD_FETCH, 0, 0, 0, 0, 0));
	endtask

	initial begin
		int unsigned rr, cc;
		err_count = 0;
		calm = 0;
		sh_rows = 64; sh_cols = 64;
		foreach (sh_pix[i]) sh_pix[i] = 0;
		foreach (sh_lab[i]) sh_lab[i] = 0;
		stk_ptr = 0; reg_sum = 0; reg_cnt = 0;
		cur_label = 0; load_idx = 0; scan_idx = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: smallest image, a two-row three-column image, extremes.
		write_geometry(rgsb_pkg::REG_ROWS, 1);
		write_geometry(rgsb_pkg::REG_COLS, 1);
		pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, 8'hff, 1, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, 8'h00, 0, 0, 0, 0)); // past the image
		pending_words.push_back(mk(rgsb_pkg::CMD_FETCH, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_SEED, 0, 0, 6'h3f, 6'h3f, 8'hff)); // out of range
		pending_words.push_back(mk(rgsb_pkg::CMD_SEED, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_SEED, 0, 0, 0, 0, 0)); // already labelled
		pending_words.push_back(mk(rgsb_pkg::CMD_FETCH, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_NONE, 8'hff, 1, 6'h3f, 6'h3f, 8'hff));
		drain();
		write_geometry(rgsb_pkg::REG_ROWS, 2);
		write_geometry(rgsb_pkg::REG_COLS, 3);
		pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, 8'h00, 1, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, 8'h00, 0, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, 8'hff, 0, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, 8'h80, 0, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, 8'h01, 0, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_LOAD, 8'hfe, 0, 0, 0, 0));
		pending_words.push_back(mk(rgsb_pkg::CMD_SEED, 0, 0, 0, 0, 8'd0));
		pending_words.push_back(mk(rgsb_pkg::CMD_SEED, 0, 0, 1, 2, 8'd255));
		repeat (4) pending_words.push_back(mk(rgsb_pkg::CMD_FETCH, 0, 0, 0, 0, 0));
		drain();

		// Random phases over a mix of geometries, including the tallest and widest.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin rr = 16; cc = 16; end
				1: begin rr = 1; cc = 64; end
				2: begin rr = 64; cc = 1; end
				3: begin rr = 127; cc = 1; end   // clamped to 64 rows
				default: begin rr = $urandom_range(1, 8); cc = $urandom_range(1, 8); end
			endcase
			if (ph == 6) calm = 1;
			write_geometry(rgsb_pkg::REG_ROWS, rr);
			write_geometry(rgsb_pkg::REG_COLS, cc);
			queue_frame(sh_rows, sh_cols, ph == 0 ? 0 : ph % 3);
			queue_work(sh_rows, sh_cols, ph == 0 ? 30 : 25);
			drain();
		end

		$display("sent %0d words (%0d taken), %0d seeds grew regions", words_sent,
			words_taken, seed_count);
		$display("checked %0d border results, %0d of them found", fetch_count, found_count);
		if (err_count == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#200000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- region_grow_segment_border.f -----
rtl/rgsb_pkg.sv
rtl/rgsb_ram.sv
rtl/rgsb_div.sv
rtl/region_grow_segment_border.sv
tb/tb_top.sv
